[src/imu_frame_parser_macros.svh]
// ---------------------------------------------------------------------------
// imu_frame_parser_macros.svh
// Assertion macros used by the IMU frame parser checker.
// ---------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_MACROS_SVH
`define IMU_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IMUFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imu_frame_parser assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define IMUFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imu_frame_parser assertion failed");

// Next-cycle implication that is also checked across reset.
`define IMUFP_ASSERT_NEXT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("imu_frame_parser reset assertion failed");

`endif

[src/imufp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imufp_pkg
// Types and constants of the IMU frame parser.
// ---------------------------------------------------------------------------
package imufp_pkg;

    // Frame framing.
    localparam logic [7:0] HEADER_BYTE = 8'h5A;
    localparam logic [3:0] POS_IDLE    = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_LAST    = 4'd10;

    // Type bytes on the wire.
    localparam logic [7:0] TYPE_ACCEL = 8'hCC;
    localparam logic [7:0] TYPE_GYRO  = 8'hAA;
    localparam logic [7:0] TYPE_ANGLE = 8'hBB;
    localparam logic [7:0] TYPE_QUAT  = 8'hDD;

    // Result kind codes.
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_QUAT  = 2'd3;

    // Full-scale factors, as small signed constants.
    localparam logic signed [11:0] SCALE_ACCEL = 12'sd16;
    localparam logic signed [11:0] SCALE_GYRO  = 12'sd2000;
    localparam logic signed [11:0] SCALE_ANGLE = 12'sd180;
    localparam logic signed [11:0] SCALE_QUAT  = 12'sd1;

    // Field widths.
    localparam int RAW_W   = 16;
    localparam int VALUE_W = 27;

    // Decoded type byte.
    typedef struct packed {
        logic       known;
        logic [1:0] kind;
    } kind_info_t;

endpackage

[src/imufp_scale.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imufp_scale
// Decodes the frame type and scales the raw values to signed fixed point with 15 fractional bits.
// ---------------------------------------------------------------------------
module imufp_scale (
    input  logic [7:0]                      type_byte,
    input  logic signed [15:0]              raw_x,
    input  logic signed [15:0]              raw_y,
    input  logic signed [15:0]              raw_z,
    input  logic signed [15:0]              raw_w,
    output imufp_pkg::kind_info_t           info,
    output logic signed [26:0]              value_x,
    output logic signed [26:0]              value_y,
    output logic signed [26:0]              value_z,
    output logic signed [15:0]              value_w
);
    import imufp_pkg::*;

    logic signed [11:0] scale;

    // raw / 32768 * scale with 15 fractional bits is just raw * scale.
    function automatic logic signed [VALUE_W-1:0] scale_raw(
        input logic signed [RAW_W-1:0] raw,
        input logic signed [11:0]      factor
    );
        logic signed [RAW_W+11:0] prod;
        prod = raw * factor;
        return prod[VALUE_W-1:0];
    endfunction

    // Map the type byte to a kind code and its scale factor.
    always_comb begin
        info.known = 1'b1;
        info.kind  = KIND_ACCEL;
        scale      = SCALE_ACCEL;
        case (type_byte)
            TYPE_ACCEL: begin
                info.kind = KIND_ACCEL;
                scale     = SCALE_ACCEL;
            end
            TYPE_GYRO: begin
                info.kind = KIND_GYRO;
                scale     = SCALE_GYRO;
            end
            TYPE_ANGLE: begin
                info.kind = KIND_ANGLE;
                scale     = SCALE_ANGLE;
            end
            TYPE_QUAT: begin
                info.kind = KIND_QUAT;
                scale     = SCALE_QUAT;
            end
            default: begin
                info.known = 1'b0;
            end
        endcase
    end

    // One small multiplier per axis; the fourth value passes only for quaternions.
    assign value_x = scale_raw(raw_x, scale);
    assign value_y = scale_raw(raw_y, scale);
    assign value_z = scale_raw(raw_z, scale);
    assign value_w = (info.kind == KIND_QUAT) ? raw_w : '0;

endmodule

[src/imu_frame_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_frame_parser
// Byte-serial parser for 11-byte IMU frames with an 8-bit sum checksum.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one received serial byte per word in s_tdata.
//   Bytes before a 0x5A header are dropped; after the header ten more bytes
//   form the frame. A frame whose checksum matches and whose type is known
//   gives one word on the master channel: the kind in m_tuser and the
//   scaled values in m_tdata. Bad or unknown frames give nothing.
//   Throughput: one byte per cycle except while a checksum byte is held off, set by
//   the position counter and the running sum, which update in the cycle a byte is taken.
//   Latency: the result is valid the cycle after the checksum byte is taken;
//   the scaling multipliers sit between the value registers and the result
//   register.
//   Stalls: while a result waits in the output register, data bytes are
//   still taken; only the next checksum byte is held off (s_tready low)
//   until the waiting result has been taken.
//   Reset: aresetn low returns the parser to header search and empties the
//   output register.
// ---------------------------------------------------------------------------
module imu_frame_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] rx_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // [26:0] value_x, [53:27] value_y,
                                     // [80:54] value_z, [96:81] value_w, zero fill
    output logic [1:0]    m_tuser    // [1:0] frame_kind
);
    import imufp_pkg::*;

    // Parser state.
    logic [3:0]             pos_reg, pos_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             type_reg, type_next;
    logic [7:0]             low_reg, low_next;
    logic [RAW_W-1:0]       raw_values_reg [4];

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             kind_reg;
    logic signed [26:0]     x_reg, y_reg, z_reg;
    logic signed [15:0]     w_reg;

    logic                   s_accept;
    logic                   load;
    logic                   raw_write;
    logic [3:0]             pos_m3;
    logic [1:0]             raw_idx;

    kind_info_t             info;
    logic signed [26:0]     sc_x, sc_y, sc_z;
    logic signed [15:0]     sc_w;

    // A checksum byte is held only while the previous result still waits.
    assign s_tready = (pos_reg != POS_LAST) || !m_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // Which raw value an odd data byte completes.
    assign pos_m3    = pos_reg - 4'd3;
    assign raw_idx   = pos_m3[2:1];
    assign raw_write = s_accept && pos_reg[0] && (pos_reg != POS_TYPE) && (pos_reg < POS_LAST);

    // Frame sequencing and running checksum.
    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        type_next = type_reg;
        low_next  = low_reg;
        load      = 1'b0;
        if (s_accept) begin
            if (pos_reg == POS_IDLE) begin
                if (s_tdata == HEADER_BYTE) begin
                    sum_next = s_tdata;
                    pos_next = POS_TYPE;
                end
            end else if (pos_reg < POS_LAST) begin
                if (pos_reg == POS_TYPE) begin
                    type_next = s_tdata;
                end else if (!pos_reg[0]) begin
                    low_next = s_tdata;
                end
                sum_next = sum_reg + s_tdata;
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next = POS_IDLE;
                load     = (s_tdata == sum_reg) && info.known;
            end
        end
    end

    // The output word empties when taken and fills on a good frame.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_IDLE;
            sum_reg     <= '0;
            type_reg    <= '0;
            low_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            low_reg     <= low_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Raw value store: little-endian, high byte completes the entry.
    always_ff @(posedge aclk) begin
        if (raw_write) begin
            raw_values_reg[raw_idx] <= {s_tdata, low_reg};
        end
    end

    // Type decode and scaling.
    imufp_scale u_scale (
        .type_byte (type_reg),
        .raw_x     (raw_values_reg[0]),
        .raw_y     (raw_values_reg[1]),
        .raw_z     (raw_values_reg[2]),
        .raw_w     (raw_values_reg[3]),
        .info      (info),
        .value_x   (sc_x),
        .value_y   (sc_y),
        .value_z   (sc_z),
        .value_w   (sc_w)
    );

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= info.kind;
            x_reg    <= sc_x;
            y_reg    <= sc_y;
            z_reg    <= sc_z;
            w_reg    <= sc_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {7'd0, w_reg, z_reg, y_reg, x_reg};

endmodule

[src/imufp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imufp_checker
// Port-level assertions for the IMU frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "imu_frame_parser_macros.svh"

module imufp_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [103:0]  m_tdata,   // [26:0] value_x, [53:27] value_y,
                                     // [80:54] value_z, [96:81] value_w, zero fill
    input  logic [1:0]    m_tuser    // [1:0] frame_kind
);
    import imufp_pkg::*;

    logic s_taken;
    logic accel_bits_ok;

    assign s_taken       = s_tvalid && s_tready;
    assign accel_bits_ok = (m_tdata[3:0] == 4'd0) && (m_tdata[103:97] == 7'd0);

    // A stalled result word holds its payload.
    `IMUFP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // Reset empties the output register.
    `IMUFP_ASSERT_NEXT_RST(a_reset_empty, !aresetn, !m_tvalid)

    // A new result only follows an accepted byte.
    `IMUFP_ASSERT_NOW(a_rose_after_byte, $rose(m_tvalid), $past(s_taken))

    // The fourth value is zero except for quaternions.
    `IMUFP_ASSERT_NOW(a_w_zero, m_tvalid && (m_tuser != KIND_QUAT), m_tdata[96:81] == 16'd0)

    // The x acceleration value is a multiple of sixteen, and the fill bits stay zero.
    `IMUFP_ASSERT_NOW(a_accel_scale, m_tvalid && (m_tuser == KIND_ACCEL), accel_bits_ok)

endmodule

bind imu_frame_parser imufp_checker u_imufp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
